[rtl/mml_pkg.sv]
// ----------------------------------------------------------------------------
// mml_pkg: shared types and constants of the MML melody parser
// Result record, event kinds, register indexes, queue sizing and note tables.
// ----------------------------------------------------------------------------
package mml_pkg;

  localparam int POS_BITS  = 16;  // width of the character position counter
  localparam int RQ_DEPTH  = 4;   // entries of the result queue
  localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

  // Event kinds.
  localparam logic [1:0] EV_TONE  = 2'd0;
  localparam logic [1:0] EV_REST  = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STD_OCTAVE = 2'd0;
  localparam logic [1:0] CFG_STICKY     = 2'd1;
  localparam logic [1:0] CFG_LONG_DOTS  = 2'd2;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [6:0]  note_number;
    logic [7:0]  note_length;
    logic [4:0]  dot_factor_eighths;
    logic [3:0]  play_eighths;
    logic [2:0]  duty_eighths;
    logic [7:0]  tempo_bpm;
    logic [15:0] error_position;
    logic        last_of_run;
  } res_t;

  // One-based semitone number of letters A..G within an octave that starts at C (C is 1).
  function automatic logic [3:0] letter_step(input logic [2:0] idx);
    case (idx)
      3'd0:    letter_step = 4'd10;
      3'd1:    letter_step = 4'd12;
      3'd2:    letter_step = 4'd1;
      3'd3:    letter_step = 4'd3;
      3'd4:    letter_step = 4'd5;
      3'd5:    letter_step = 4'd6;
      3'd6:    letter_step = 4'd8;
      default: letter_step = 4'd0;
    endcase
  endfunction

  // A flat lowers every letter but C and F; a sharp raises every letter but B and E.
  function automatic logic has_flat(input logic [2:0] idx);
    has_flat = (idx != 3'd2) && (idx != 3'd5) && (idx <= 3'd6);
  endfunction

  function automatic logic has_sharp(input logic [2:0] idx);
    has_sharp = (idx != 3'd1) && (idx != 3'd4) && (idx <= 3'd6);
  endfunction

  function automatic logic [4:0] dot_eighths(input logic [2:0] dots, input logic long_dots);
    case (dots)
      3'd1:    dot_eighths = 5'd12;
      3'd2:    dot_eighths = long_dots ? 5'd18 : 5'd14;
      3'd3:    dot_eighths = long_dots ? 5'd27 : 5'd15;
      default: dot_eighths = 5'd8;
    endcase
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [6:0] note,
                                  input logic [7:0] len, input logic [4:0] dotf,
                                  input logic [3:0] play, input logic [2:0] duty,
                                  input logic [7:0] tempo, input logic [15:0] pos);
    res_t r;
    r.event_kind         = kind;
    r.note_number        = note;
    r.note_length        = len;
    r.dot_factor_eighths = dotf;
    r.play_eighths       = play;
    r.duty_eighths       = duty;
    r.tempo_bpm          = tempo;
    r.error_position     = pos;
    r.last_of_run        = 1'b0;
    mk_res = r;
  endfunction

endpackage

[rtl/mml_melody_parser.sv]
// ----------------------------------------------------------------------------
// mml_melody_parser: streaming MML melody parser
// Path: a byte is held in the input register, decoded together with the parser state,
// and its results are written into the result queue, which offers them one at a time.
// Throughput: one byte per cycle while the result channel keeps up; a byte makes
// zero, one or two results, and the two-entry headroom of the result queue sets
// when the input register may move on.
// Reset: synchronous rst_n restores parser defaults, empties the queue and clears config.
// ----------------------------------------------------------------------------
module mml_melody_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  input  logic [0:0]  in_tuser,   // start_flag[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // event_kind[1:0], note_number[8:2], note_length[16:9], dot_factor_eighths[21:17],
  // play_eighths[25:22], duty_eighths[28:26], tempo_bpm[36:29],
  // error_position[52:37], zero[55:53]
  output logic [55:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [0:0]  cfg_wdata
);

  logic          q_room;
  logic [1:0]    push_cnt;
  mml_pkg::res_t push_res0, push_res1, out_res;

  mml_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .in_start  (in_tuser[0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata[0]),
    .q_room    (q_room),
    .push_cnt  (push_cnt),
    .push_res0 (push_res0),
    .push_res1 (push_res1)
  );

  mml_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_res0 (push_res0),
    .push_res1 (push_res1),
    .q_room    (q_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {3'b000, out_res.error_position, out_res.tempo_bpm,
                      out_res.duty_eighths, out_res.play_eighths,
                      out_res.dot_factor_eighths, out_res.note_length,
                      out_res.note_number, out_res.event_kind};
  assign out_tlast = out_res.last_of_run;

endmodule

[rtl/mml_parse_core.sv]
// ----------------------------------------------------------------------------
// mml_parse_core: input register, parser state and one-pass decode
// Decodes the registered byte against the parser state and hands zero, one or
// two result records to the result queue in the same cycle.
// ----------------------------------------------------------------------------
module mml_parse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              in_start,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic              cfg_wdata,
  input  logic              q_room,
  output logic [1:0]        push_cnt,
  output mml_pkg::res_t     push_res0,
  output mml_pkg::res_t     push_res1
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_NOTE_MOD  = 4'd1;
  localparam logic [3:0] PH_NOTE_NUM  = 4'd2;
  localparam logic [3:0] PH_NOTE_DOTS = 4'd3;
  localparam logic [3:0] PH_REST_NUM  = 4'd4;
  localparam logic [3:0] PH_REST_DOTS = 4'd5;
  localparam logic [3:0] PH_CMD_M     = 4'd6;
  localparam logic [3:0] PH_NUM_L     = 4'd7;
  localparam logic [3:0] PH_NUM_N     = 4'd8;
  localparam logic [3:0] PH_NUM_O     = 4'd9;
  localparam logic [3:0] PH_NUM_Q     = 4'd10;
  localparam logic [3:0] PH_NUM_T     = 4'd11;
  localparam logic [3:0] PH_COMMENT   = 4'd12;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef struct packed {
    logic [3:0]                    phase;
    logic signed [8:0]             pend;
    logic [15:0]                   acc;
    logic [2:0]                    dots;
    logic [2:0]                    oct;
    logic signed [3:0]             shift;
    logic [7:0]                    tempo;
    logic [6:0]                    dlen;
    logic [3:0]                    style;
    logic [2:0]                    duty;
    logic [mml_pkg::POS_BITS-1:0]  pos;
    logic                          stopped;
    logic [2:0]                    letter;
  } parse_state_t;

  localparam parse_state_t ST_RESET = '{
    phase:   PH_IDLE,
    pend:    9'sd0,
    acc:     16'd0,
    dots:    3'd0,
    oct:     3'd4,
    shift:   4'sd0,
    tempo:   8'd120,
    dlen:    7'd4,
    style:   4'd7,
    duty:    3'd4,
    pos:     '0,
    stopped: 1'b0,
    letter:  3'd0
  };

  parse_state_t st_r, st_nxt;
  logic         in_valid_r;
  logic [7:0]   in_char_r;
  logic         in_start_r;
  logic         std_oct_r, sticky_r, long_dots_r;
  logic         proc;

  logic [7:0]         c;
  logic               digit;
  logic               done;
  logic [3:0]         ph;
  logic [1:0]         k;
  logic [19:0]        acc10;
  logic signed [8:0]  sh9;
  logic signed [8:0]  sh12;
  logic signed [17:0] n18;
  logic signed [4:0]  oct5;
  logic signed [8:0]  oct9;
  logic [7:0]         len8;
  logic               emit_idle;
  mml_pkg::res_t      r_idle;
  mml_pkg::res_t      r0, r1;

  // The register stage moves on only when the queue can take two records.
  assign proc     = in_valid_r && q_room;
  assign in_ready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      st_r        <= ST_RESET;
      std_oct_r   <= 1'b0;
      sticky_r    <= 1'b0;
      long_dots_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mml_pkg::CFG_STD_OCTAVE: std_oct_r   <= cfg_wdata;
          mml_pkg::CFG_STICKY:     sticky_r    <= cfg_wdata;
          mml_pkg::CFG_LONG_DOTS:  long_dots_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r  <= in_char;
      in_start_r <= in_start;
    end
  end

  assign c     = in_char_r;
  assign digit = (c >= CH_0) && (c <= CH_9);

  always_comb begin
    st_nxt    = st_r;
    done      = 1'b0;
    ph        = st_r.phase;
    k         = 2'd0;
    r0        = '0;
    r1        = '0;
    r_idle    = '0;
    emit_idle = 1'b0;
    acc10     = '0;
    sh9       = '0;
    sh12      = '0;
    n18       = '0;
    oct5      = '0;
    oct9      = '0;
    len8      = '0;
    if (proc) begin
      if (in_start_r) begin
        st_nxt = ST_RESET;
      end
      if (!st_nxt.stopped) begin
        if (st_nxt.pos != '1) begin
          st_nxt.pos = st_nxt.pos + 1'b1;
        end
        ph = st_nxt.phase;

        // Accidental right after a note letter.
        if (ph == PH_NOTE_MOD) begin
          st_nxt.phase = PH_NOTE_NUM;
          ph           = PH_NOTE_NUM;
          if (c == CH_MINUS) begin
            if (mml_pkg::has_flat(st_nxt.letter)) st_nxt.pend = st_nxt.pend - 9'sd1;
            done = 1'b1;
          end else if (c == CH_PLUS || c == CH_HASH) begin
            if (mml_pkg::has_sharp(st_nxt.letter)) st_nxt.pend = st_nxt.pend + 9'sd1;
            done = 1'b1;
          end
        end

        // Number collection; a non-digit closes the number.
        if (!done && (ph == PH_NOTE_NUM || ph == PH_REST_NUM ||
                      (ph >= PH_NUM_L && ph <= PH_NUM_T))) begin
          if (digit) begin
            acc10 = ({4'd0, st_nxt.acc} << 3) + ({4'd0, st_nxt.acc} << 1) +
                    {12'd0, c - CH_0};
            st_nxt.acc   = (acc10[19:16] != 4'd0) ? 16'hFFFF : acc10[15:0];
            st_nxt.phase = ph;
            done         = 1'b1;
          end else if (ph == PH_NOTE_NUM) begin
            ph = PH_NOTE_DOTS;
          end else if (ph == PH_REST_NUM) begin
            ph = PH_REST_DOTS;
          end else begin
            case (ph)
              PH_NUM_L: begin
                if (st_nxt.acc >= 16'd1 && st_nxt.acc <= 16'd64) begin
                  st_nxt.dlen = st_nxt.acc[6:0];
                end
              end
              PH_NUM_N: begin
                sh9  = 9'(st_nxt.shift);
                sh12 = (sh9 <<< 3) + (sh9 <<< 2);
                n18  = $signed({2'b00, st_nxt.acc}) + 18'(sh12);
                if (!sticky_r) st_nxt.shift = 4'sd0;
                if (n18 >= 18'sd1 && n18 <= 18'sd84) begin
                  r0 = mml_pkg::mk_res(mml_pkg::EV_TONE, n18[6:0], {1'b0, st_nxt.dlen},
                                       5'd8, st_nxt.style, st_nxt.duty, st_nxt.tempo, 16'd0);
                end else begin
                  r0 = mml_pkg::mk_res(mml_pkg::EV_REST, 7'd0, {1'b0, st_nxt.dlen},
                                       5'd8, st_nxt.style, st_nxt.duty, st_nxt.tempo, 16'd0);
                end
                k = 2'd1;
              end
              PH_NUM_O: begin
                if (std_oct_r ? (st_nxt.acc >= 16'd1 && st_nxt.acc <= 16'd7)
                              : (st_nxt.acc <= 16'd6)) begin
                  st_nxt.oct = st_nxt.acc[2:0];
                end
              end
              PH_NUM_Q: begin
                if (st_nxt.acc >= 16'd1 && st_nxt.acc <= 16'd4) begin
                  st_nxt.duty = st_nxt.acc[2:0];
                end
              end
              default: begin
                if (st_nxt.acc >= 16'd32 && st_nxt.acc <= 16'd255) begin
                  st_nxt.tempo = st_nxt.acc[7:0];
                end
              end
            endcase
            ph = PH_IDLE;
          end
        end

        // Dot run; anything else finishes the note or rest.
        if (!done && (ph == PH_NOTE_DOTS || ph == PH_REST_DOTS)) begin
          if (c == CH_DOT) begin
            if (st_nxt.dots != 3'd7) st_nxt.dots = st_nxt.dots + 3'd1;
            st_nxt.phase = ph;
            done         = 1'b1;
          end else begin
            if (st_nxt.acc == 16'd0) begin
              len8 = {1'b0, st_nxt.dlen};
            end else begin
              len8 = (st_nxt.acc[15:8] != 8'd0) ? 8'hFF : st_nxt.acc[7:0];
            end
            if (ph == PH_NOTE_DOTS && st_nxt.pend >= 9'sd1 && st_nxt.pend <= 9'sd84) begin
              r0 = mml_pkg::mk_res(mml_pkg::EV_TONE, st_nxt.pend[6:0], len8,
                                   mml_pkg::dot_eighths(st_nxt.dots, long_dots_r),
                                   st_nxt.style, st_nxt.duty, st_nxt.tempo, 16'd0);
            end else begin
              r0 = mml_pkg::mk_res(mml_pkg::EV_REST, 7'd0, len8,
                                   mml_pkg::dot_eighths(st_nxt.dots, long_dots_r),
                                   st_nxt.style, st_nxt.duty, st_nxt.tempo, 16'd0);
            end
            k  = 2'd1;
            ph = PH_IDLE;
          end
        end

        if (!done) begin
          if (ph == PH_CMD_M) begin
            st_nxt.phase = PH_IDLE;
            case (c)
              CH_L:    st_nxt.style = 4'd8;
              CH_N:    st_nxt.style = 4'd7;
              CH_S:    st_nxt.style = 4'd6;
              CH_NUL: begin
                emit_idle      = 1'b1;
                st_nxt.stopped = 1'b1;
              end
              default: ;
            endcase
          end else if (ph == PH_COMMENT) begin
            if (c == CH_LF) begin
              st_nxt.phase = PH_IDLE;
            end else if (c == CH_NUL) begin
              st_nxt.phase   = PH_IDLE;
              emit_idle      = 1'b1;
              st_nxt.stopped = 1'b1;
            end
          end else begin
            st_nxt.phase = PH_IDLE;
            if (c inside {[CH_A:CH_G]}) begin
              st_nxt.letter = 3'(c - CH_A);
              oct5 = $signed({2'b00, st_nxt.oct}) - $signed({4'd0, std_oct_r}) +
                     5'(st_nxt.shift);
              oct9 = 9'(oct5);
              st_nxt.pend = (oct9 <<< 3) + (oct9 <<< 2) +
                            $signed({5'd0, mml_pkg::letter_step(st_nxt.letter)});
              if (!sticky_r) st_nxt.shift = 4'sd0;
              st_nxt.acc   = 16'd0;
              st_nxt.dots  = 3'd0;
              st_nxt.phase = PH_NOTE_MOD;
            end else if (c inside {CH_P, CH_R}) begin
              st_nxt.acc   = 16'd0;
              st_nxt.dots  = 3'd0;
              st_nxt.phase = PH_REST_NUM;
            end else if (c inside {CH_L, CH_N, CH_O, CH_Q, CH_T}) begin
              st_nxt.acc = 16'd0;
              case (c)
                CH_L:    st_nxt.phase = PH_NUM_L;
                CH_N:    st_nxt.phase = PH_NUM_N;
                CH_O:    st_nxt.phase = PH_NUM_O;
                CH_Q:    st_nxt.phase = PH_NUM_Q;
                default: st_nxt.phase = PH_NUM_T;
              endcase
            end else if (c == CH_M) begin
              st_nxt.phase = PH_CMD_M;
            end else if (c == CH_LT) begin
              if (st_nxt.shift != -4'sd8) st_nxt.shift = st_nxt.shift - 4'sd1;
            end else if (c == CH_GT) begin
              if (st_nxt.shift != 4'sd7) st_nxt.shift = st_nxt.shift + 4'sd1;
            end else if (c inside {CH_COLON, CH_HASH}) begin
              st_nxt.phase = PH_COMMENT;
            end else if (c inside {CH_K, CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
              // Separators and the keyboard command are skipped.
            end else if (c == CH_NUL) begin
              emit_idle      = 1'b1;
              st_nxt.stopped = 1'b1;
            end else begin
              r_idle = mml_pkg::mk_res(mml_pkg::EV_ERROR, 7'd0, 8'd0, 5'd0, st_nxt.style,
                                       st_nxt.duty, st_nxt.tempo, 16'(st_nxt.pos));
              emit_idle      = 1'b1;
              st_nxt.stopped = 1'b1;
            end
          end
          // An end record is the default when no error was built above.
          if (emit_idle && r_idle.event_kind != mml_pkg::EV_ERROR) begin
            r_idle = mml_pkg::mk_res(mml_pkg::EV_END, 7'd0, 8'd0, 5'd0, st_nxt.style,
                                     st_nxt.duty, st_nxt.tempo, 16'd0);
          end
          if (emit_idle) begin
            if (k == 2'd0) r0 = r_idle;
            else           r1 = r_idle;
            k = k + 2'd1;
          end
        end
      end
    end
    r0.last_of_run = (k == 2'd1);
    r1.last_of_run = 1'b1;
  end

  assign push_cnt  = k;
  assign push_res0 = r0;
  assign push_res1 = r1;

  a_first_of_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd2) |->
      (push_res0.event_kind == mml_pkg::EV_TONE || push_res0.event_kind == mml_pkg::EV_REST))
    else $error("first of two records is not a tone or rest");

  a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stopped |-> (st_r.phase == PH_IDLE))
    else $error("parser stopped outside the idle phase");

  a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> proc)
    else $error("records pushed without a registered transaction");

endmodule

[rtl/mml_result_queue.sv]
// ----------------------------------------------------------------------------
// mml_result_queue: small queue of result records
// Takes up to two records per cycle from the parser and presents them one at a
// time on the result channel.
// ----------------------------------------------------------------------------
module mml_result_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  mml_pkg::res_t  push_res0,
  input  mml_pkg::res_t  push_res1,
  output logic           q_room,
  output logic           out_valid,
  input  logic           out_ready,
  output mml_pkg::res_t  out_res
);

  mml_pkg::res_t                  mem_r [mml_pkg::RQ_DEPTH];
  logic [mml_pkg::RQ_PTR_W-1:0]   wr_r, rd_r, wr_nxt, rd_nxt;
  logic [mml_pkg::RQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                           pop;

  assign q_room    = (cnt_r <= mml_pkg::RQ_CNT_W'(mml_pkg::RQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_nxt  = wr_r + mml_pkg::RQ_PTR_W'(push_cnt);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + mml_pkg::RQ_CNT_W'(push_cnt) - mml_pkg::RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_r] <= push_res0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_r + 1'b1] <= push_res1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mml_pkg::RQ_CNT_W'(mml_pkg::RQ_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> q_room)
    else $error("records pushed without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != mml_pkg::RQ_CNT_W'(mml_pkg::RQ_DEPTH)) |->
      (mml_pkg::RQ_PTR_W'(wr_r - rd_r) == mml_pkg::RQ_PTR_W'(cnt_r)))
    else $error("queue pointers disagree with fill count");

endmodule
